// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the response checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent at one edge requires consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg
// types, constants and the crc byte update for the response checker
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam logic [7:0]  FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0]  VALUE_BYTE_COUNT = 8'd2;
   localparam logic [7:0]  MIN_FRAME_LEN    = 8'd5;
   localparam logic [7:0]  COUNT_MAX        = 8'd255;
   localparam int          HEADER_DEPTH     = 4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } mrc_req_type;

   typedef struct packed {
      logic [7:0]  frame_length;
      logic        crc_ok;
      logic        value_valid;
      logic [15:0] reg_value;
   } mrc_rsp_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/mrc_input_reg.sv =====
// ----------------------------------------------------------------------------
// mrc_input_reg
// input register stage holding one byte item ahead of the frame logic
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_input_reg (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  mrc_pkg::mrc_req_type req_data,
   input  wire                 out_free,
   output logic                advance,
   output mrc_pkg::mrc_req_type item
);
   import mrc_pkg::*;

   logic        in_valid_ff, in_valid_in;
   mrc_req_type item_ff;
   logic        load;

   // the held item moves on unless it ends a frame and the result slot is busy
   assign advance   = in_valid_ff & (~item_ff.frame_end | out_free);
   assign req_stall = in_valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;
   assign in_valid_in = load | (in_valid_ff & ~advance);
   assign item      = item_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/mrc_frame_core.sv =====
// ----------------------------------------------------------------------------
// mrc_frame_core
// per-frame state: crc, byte count, trailing and header bytes, result build
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mrc_frame_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  advance,
   input  mrc_pkg::mrc_req_type item,
   output logic                 result_load,
   output mrc_pkg::mrc_rsp_type result
);
   import mrc_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  trail_ff [2];
   logic [7:0]  head_ff  [HEADER_DEPTH];
   logic [7:0]  head_in  [HEADER_DEPTH];
   logic        long_enough;
   logic        val_ok;
   logic [15:0] rx_crc;

   assign result_load = advance & item.frame_end;

   // next state for one byte
   always_comb begin
      crc_in = (count_ff >= 8'd2) ? crc_feed(crc_ff, trail_ff[0]) : crc_ff;
      count_in = (count_ff != COUNT_MAX) ? count_ff + 8'd1 : count_ff;
      for (int i = 0; i < HEADER_DEPTH; i++) begin
         head_in[i] = (count_ff == 8'(i + 1)) ? item.rx_byte : head_ff[i];
      end
   end

   // result for a frame that ends with this byte
   assign long_enough = (count_in >= MIN_FRAME_LEN);
   assign rx_crc      = {item.rx_byte, trail_ff[1]};
   assign val_ok      = long_enough & (head_in[0] == FC_READ_HOLDING) &
                        (head_in[1] == VALUE_BYTE_COUNT);

   always_comb begin
      result.frame_length = count_in;
      result.crc_ok       = long_enough & (crc_in == rx_crc);
      result.value_valid  = val_ok;
      result.reg_value    = val_ok ? {head_in[2], head_in[3]} : 16'h0000;
   end

   // frame state, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset || result_load) begin
         crc_ff   <= CRC_INIT;
         count_ff <= 8'd0;
         trail_ff[0] <= 8'd0;
         trail_ff[1] <= 8'd0;
         for (int i = 0; i < HEADER_DEPTH; i++) begin
            head_ff[i] <= 8'd0;
         end
      end else if (advance) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         trail_ff[0] <= trail_ff[1];
         trail_ff[1] <= item.rx_byte;
         for (int i = 0; i < HEADER_DEPTH; i++) begin
            head_ff[i] <= head_in[i];
         end
      end
   end

   `ASSERT_NEXT(a_clear_after_end, clock, reset, result_load,
      (count_ff == 8'd0) && (crc_ff == CRC_INIT), "frame state not cleared after last byte")
   `ASSERT_NEXT(a_count_steps, clock, reset,
      advance && !item.frame_end && (count_ff != COUNT_MAX),
      count_ff == $past(count_ff) + 8'd1, "byte count did not step")
   `ASSERT_ALWAYS(a_short_no_crc, clock, reset,
      !(result_load && result.crc_ok) || (result.frame_length >= MIN_FRAME_LEN),
      "crc ok on a short frame")
   `ASSERT_ALWAYS(a_value_gated, clock, reset,
      result.value_valid || (result.reg_value == 16'h0000), "register value without valid flag")

endmodule

`default_nettype wire

// ===== src/mrc_output_reg.sv =====
// ----------------------------------------------------------------------------
// mrc_output_reg
// result register toward the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_output_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  result_load,
   input  mrc_pkg::mrc_rsp_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output mrc_pkg::mrc_rsp_type rsp_data
);
   import mrc_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   mrc_rsp_type rsp_ff;

   // slot can take a new item when empty or being taken this cycle
   assign out_free     = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in = result_load | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== src/modbus_rtu_response_checker.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// checks a modbus rtu response frame byte by byte and reports one result
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one frame byte per item, frame_end set on the last
//   byte. rsp channel carries one item per frame: length (saturating at 255),
//   crc match over all but the final two bytes (received crc, low byte
//   first), and the register value of a read-holding reply with byte count 2.
//   frames under five bytes report crc_ok and value_valid low.
// result path: after the last byte is accepted it passes the input
//   register and then the result register before rsp_valid rises; a
//   full result register holds the frame end in the input register.
// throughput: one byte per cycle while not stalled; the crc update is one
//   unrolled byte step between the input register and the frame state.
// reset: clears both channel valids and the frame state; crc restarts at
//   0xFFFF and the byte count at zero.
// stall: a stalled result holds; the input stage keeps taking bytes that do
//   not end a frame, and stalls only when a frame end waits for the result
//   register.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_checker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  mrc_pkg::mrc_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output mrc_pkg::mrc_rsp_type rsp_data
);
   import mrc_pkg::*;

   logic        out_free;
   logic        advance;
   logic        result_load;
   mrc_req_type item;
   mrc_rsp_type result;

   // input register stage
   mrc_input_reg u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .advance   (advance),
      .item      (item)
   );

   // frame state and result logic
   mrc_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (item),
      .result_load (result_load),
      .result      (result)
   );

   // result register
   mrc_output_reg u_output (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the modbus rtu response checker: sends response
// frames one byte per item, predicts each frame report and compares it field
// by field with what the block returns
// ----------------------------------------------------------------------------

typedef logic [7:0] byte_q_type[$];

// reflected crc-16 update, one data bit folded in per shift
function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
   logic [15:0] c;
   logic        fb;
   c = crc;
   for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) begin
         c = c ^ mrc_pkg::CRC_POLY;
      end
   end
   return c;
endfunction

// append the frame crc, low byte first
function automatic void append_crc(ref byte_q_type q);
   logic [15:0] c;
   c = mrc_pkg::CRC_INIT;
   foreach (q[i]) begin
      c = crc16_byte(c, q[i]);
   end
   q.push_back(c[7:0]);
   q.push_back(c[15:8]);
endfunction

// random byte with the all-zero and all-one values made common
function automatic logic [7:0] pick_byte();
   case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
   endcase
endfunction

// tracks the frame in progress and holds the reports still owed by the block
class frame_crc_tracker;
   logic [15:0] crc_run;
   logic [7:0]  count;
   logic [7:0]  tail [2];
   logic [7:0]  hdr  [4];
   mrc_pkg::mrc_rsp_type frame_reports[$];
   int errors;

   function new();
      clear();
      errors = 0;
   endfunction

   function void clear();
      crc_run = mrc_pkg::CRC_INIT;
      count   = '0;
      tail    = '{default: 8'h00};
      hdr     = '{default: 8'h00};
   endfunction

   function int pending();
      return frame_reports.size();
   endfunction

   // one accepted byte; a frame end produces an expected report
   function void note_byte(input mrc_pkg::mrc_req_type item);
      logic                 long_enough;
      logic [15:0]          rx_crc;
      mrc_pkg::mrc_rsp_type rep;
      // the byte leaving the trailing pair is now part of the crc
      if (count >= 2) begin
         crc_run = crc16_byte(crc_run, tail[0]);
      end
      tail[0] = tail[1];
      tail[1] = item.rx_byte;
      if (count >= 1 && count <= 4) begin
         hdr[count - 1] = item.rx_byte;
      end
      if (count != mrc_pkg::COUNT_MAX) begin
         count = count + 8'd1;
      end
      if (item.frame_end) begin
         long_enough      = count >= mrc_pkg::MIN_FRAME_LEN;
         rx_crc           = {tail[1], tail[0]};
         rep.frame_length = count;
         rep.crc_ok       = long_enough && (crc_run == rx_crc);
         rep.value_valid  = long_enough && hdr[0] == mrc_pkg::FC_READ_HOLDING &&
                            hdr[1] == mrc_pkg::VALUE_BYTE_COUNT;
         rep.reg_value    = rep.value_valid ? {hdr[2], hdr[3]} : 16'h0000;
         frame_reports.push_back(rep);
         clear();
      end
   endfunction

   // compare one returned report with the oldest one owed
   function void check_result(input mrc_pkg::mrc_rsp_type got);
      mrc_pkg::mrc_rsp_type want;
      if (frame_reports.size() == 0) begin
         $display("%0t unexpected report: expected none, actual length %0d crc_ok %0b",
                  $time, got.frame_length, got.crc_ok);
         errors++;
         return;
      end
      want = frame_reports.pop_front();
      if (got.frame_length !== want.frame_length) begin
         $display("%0t frame_length: expected %0d, actual %0d",
                  $time, want.frame_length, got.frame_length);
         errors++;
      end
      if (got.crc_ok !== want.crc_ok) begin
         $display("%0t crc_ok: expected %0b, actual %0b", $time, want.crc_ok, got.crc_ok);
         errors++;
      end
      if (got.value_valid !== want.value_valid) begin
         $display("%0t value_valid: expected %0b, actual %0b",
                  $time, want.value_valid, got.value_valid);
         errors++;
      end
      if (got.reg_value !== want.reg_value) begin
         $display("%0t reg_value: expected %h, actual %h", $time, want.reg_value, got.reg_value);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import mrc_pkg::*;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mrc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mrc_rsp_type rsp_data;

   int burst_left   = 0;
   bit steady_phase = 1'b0;
   bit valid_held   = 1'b0;
   int stall_mode   = 0;
   int stall_left   = 0;

   frame_crc_tracker tracker = new();

   modbus_rtu_response_checker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // receiver stall pattern: free running, coin flip, heavy, periodic
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 1) == 1);
         2:       rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= ((stall_left % 16) < 5);
      endcase
   end

   // note accepted bytes before checking reports of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.note_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_result(rsp_data);
         end
      end
   end

   // send one frame, one byte per item, in bursts with random gaps
   task automatic send_frame(input byte_q_type bytes);
      mrc_req_type item;
      int          gap;
      foreach (bytes[i]) begin
         item.rx_byte   = bytes[i];
         item.frame_end = (i == bytes.size() - 1);
         req_data  <= item;
         req_valid <= 1'b1;
         @(posedge clock);
         while (req_stall) begin
            @(posedge clock);
         end
         valid_held = 1'b1;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap        = steady_phase ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               valid_held = 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // stimulus
   initial begin
      byte_q_type frame;
      int         random_bytes;
      int         kind;
      int         len;
      int         pos;
      int         guard;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one and two byte frames, short frames, short frame with a valid crc
      send_frame('{8'hFF});
      send_frame('{8'h00, 8'hFF});
      send_frame('{8'h01, FC_READ_HOLDING, VALUE_BYTE_COUNT});
      frame = '{8'h01, FC_READ_HOLDING};
      append_crc(frame);
      send_frame(frame);
      // read reply with the largest value, then an exception reply
      frame = '{8'h01, FC_READ_HOLDING, VALUE_BYTE_COUNT, 8'hFF, 8'hFF};
      append_crc(frame);
      send_frame(frame);
      frame = '{8'hFF, 8'h83, 8'h02};
      append_crc(frame);
      send_frame(frame);

      // random frames, mostly well formed read replies
      random_bytes = 0;
      while (random_bytes < 1600) begin
         if ($urandom_range(0, 7) == 0) begin
            steady_phase = !steady_phase;
         end
         frame = {};
         kind  = $urandom_range(0, 99);
         if (kind < 2) begin
            // long frame, the length counter saturates for most lengths
            len = $urandom_range(250, 300);
            repeat (len - 2) frame.push_back(pick_byte());
            append_crc(frame);
         end else if (kind < 55) begin
            frame.push_back(pick_byte());
            frame.push_back(FC_READ_HOLDING);
            frame.push_back(VALUE_BYTE_COUNT);
            frame.push_back(pick_byte());
            frame.push_back(pick_byte());
            append_crc(frame);
         end else if (kind < 70) begin
            // other replies with a good crc, some near misses of a read reply
            len = $urandom_range(3, 16);
            frame.push_back(pick_byte());
            frame.push_back(($urandom_range(0, 1) == 1) ? FC_READ_HOLDING : pick_byte());
            frame.push_back(8'($urandom_range(0, 4)));
            repeat (len - 3) frame.push_back(pick_byte());
            append_crc(frame);
         end else if (kind < 85) begin
            len = $urandom_range(1, 4);
            repeat (len) frame.push_back(pick_byte());
         end else begin
            len = $urandom_range(5, 12);
            repeat (len) frame.push_back(pick_byte());
         end
         // corrupt one bit now and then
         if (frame.size() >= 5 && $urandom_range(0, 7) == 0) begin
            pos        = $urandom_range(0, frame.size() - 1);
            frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
         end
         send_frame(frame);
         random_bytes += frame.size();
      end
      if (valid_held) begin
         req_valid <= 1'b0;
      end

      // drain outstanding reports, then wait for stray ones
      guard = 0;
      while (tracker.pending() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0) begin
         $display("%0t missing reports: expected %0d more, actual 0", $time, tracker.pending());
      end
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
